/* hw/rtl/dmtr_pkg.sv */
// ----------------------------------------------------------------------------
// dmtr_pkg
// Shared types, register indexes and the 5x7 glyph ROM of the dot-matrix
// text renderer.
// ----------------------------------------------------------------------------
package dmtr_pkg;

    localparam int GLYPH_W       = 5;
    localparam int GLYPH_H       = 7;
    localparam int GLYPH_DOTS    = GLYPH_W * GLYPH_H;
    localparam int ADVANCE_CELLS = 6;
    localparam int CASE_FOLD     = 32;
    localparam int GLYPH_SPACE   = 36;
    localparam int COORD_W       = 14;

    // rotation codes; the spare code draws unrotated
    localparam logic [1:0] ROT_CW  = 2'd1;
    localparam logic [1:0] ROT_CCW = 2'd2;

    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_CELL_SIZE   = 3'd2,
        REG_ROTATION    = 3'd3,
        REG_GRID_ENABLE = 3'd4,
        REG_TEXT_LENGTH = 3'd5,
        REG_ON_COLOUR   = 3'd6,
        REG_OFF_COLOUR  = 3'd7
    } t_reg_idx;

    typedef logic [GLYPH_DOTS-1:0] t_glyph;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [3:0]  cell_size;
        logic [1:0]  rotation;
        logic        grid_enable;
        logic [6:0]  text_length;
        logic [15:0] on_colour;
        logic [15:0] off_colour;
    } t_cfg;

    // character code to ROM index; lowercase folds, unknown codes map to space
    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [7:0] u;
        logic [5:0] idx;
        u = code;
        if (code inside {[8'h61:8'h7A]}) begin
            u = code - 8'(CASE_FOLD);
        end
        if (u inside {[8'h41:8'h5A]}) begin
            idx = 6'(u - 8'h41) + 6'd10;
        end else if (u inside {[8'h30:8'h39]}) begin
            idx = 6'(u - 8'h30);
        end else begin
            case (u)
                8'h3A:   idx = 6'd37;  // colon
                8'h2F:   idx = 6'd38;  // slash
                8'h2D:   idx = 6'd39;  // minus
                8'h2E:   idx = 6'd40;  // period
                8'h3C:   idx = 6'd41;  // less-than
                8'h3E:   idx = 6'd42;  // greater-than
                8'h2B:   idx = 6'd43;  // plus
                default: idx = 6'(GLYPH_SPACE);
            endcase
        end
        return idx;
    endfunction

    // raw ROM: row 0 in the top bits, each row MSB = leftmost column
    function automatic t_glyph glyph_raw(input logic [5:0] idx);
        t_glyph g;
        case (idx)
            6'd0:    g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
            6'd1:    g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
            6'd2:    g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
            6'd3:    g = {5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E};
            6'd4:    g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
            6'd5:    g = {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E};
            6'd6:    g = {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
            6'd7:    g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
            6'd8:    g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
            6'd9:    g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C};
            6'd10:   g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            6'd11:   g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
            6'd12:   g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
            6'd13:   g = {5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C};
            6'd14:   g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
            6'd15:   g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
            6'd16:   g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F};
            6'd17:   g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            6'd18:   g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
            6'd19:   g = {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C};
            6'd20:   g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
            6'd21:   g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
            6'd22:   g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
            6'd23:   g = {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11};
            6'd24:   g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            6'd25:   g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
            6'd26:   g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
            6'd27:   g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
            6'd28:   g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
            6'd29:   g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
            6'd30:   g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            6'd31:   g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
            6'd32:   g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11};
            6'd33:   g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
            6'd34:   g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
            6'd35:   g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
            6'd37:   g = {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00};
            6'd38:   g = {5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10};
            6'd39:   g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
            6'd40:   g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C};
            6'd41:   g = {5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02};
            6'd42:   g = {5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08};
            6'd43:   g = {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00};
            default: g = '0;  // space
        endcase
        return g;
    endfunction

    // scan-order bitmap: bit (row*5 + col) set for a lit dot
    function automatic t_glyph glyph_bits(input logic [5:0] idx);
        t_glyph raw;
        t_glyph bits;
        raw = glyph_raw(idx);
        for (int p = 0; p < GLYPH_DOTS; p++) begin
            bits[p] = raw[GLYPH_DOTS-1-p];
        end
        return bits;
    endfunction

endpackage

/* hw/rtl/dmtr_seq.sv */
// ----------------------------------------------------------------------------
// dmtr_seq
// Row/column dot sequencer: scans a glyph bitmap, one dot position per cycle
// unless output stalls, and places each dot via a registered output stage.
// ----------------------------------------------------------------------------
module dmtr_seq
    import dmtr_pkg::*;
#(
    parameter int MAX_CHARS = 64,
    parameter int MAX_CELL  = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_in_text,
    output logic               o_dot_valid,
    input  logic               i_dot_ready,
    output logic [COORD_W-1:0] o_rect_x,
    output logic [COORD_W-1:0] o_rect_y,
    output logic [3:0]         o_rect_side,
    output logic [15:0]        o_dot_colour,
    output logic               o_dot_lit,
    output logic               o_last_of_char
);

    typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN} t_state;

    t_state               r_state;
    t_glyph               r_bits;       // lit dots of the current glyph
    t_glyph               r_rem;        // dots left in this pass, bit 0 = current
    logic                 r_pass;       // 0 unlit grid pass, 1 lit pass
    logic                 r_last_text;
    logic [3:0]           r_cell;
    logic [3:0]           r_side;
    logic [9:0]           r_nm;         // 6n-1 cells of text width, 0 for no text
    logic [COORD_W-1:0]   r_bx1;        // clockwise x base
    logic [COORD_W-1:0]   r_by2;        // counter-clockwise y base
    logic [12:0]          r_cursor;
    logic [2:0]           r_col;
    logic [2:0]           r_row;
    logic [COORD_W-1:0]   r_lx;
    logic [6:0]           r_ly;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_x;
    logic [COORD_W-1:0]   r_out_y;
    logic [15:0]          r_out_colour;
    logic                 r_out_lit;
    logic                 r_out_last;

    logic                 w_accept;
    logic                 w_step;
    logic                 w_emit;
    logic                 w_finish;
    logic                 w_last_dot;
    logic [3:0]           w_cell;
    logic [6:0]           w_n;
    logic [COORD_W-1:0]   w_x0;
    logic [COORD_W-1:0]   w_y0;
    logic [COORD_W-1:0]   w_h;
    logic [COORD_W-1:0]   w_w;
    logic [COORD_W-1:0]   w_ly;
    logic [COORD_W-1:0]   w_sx;
    logic [COORD_W-1:0]   w_sy;
    logic [12:0]          w_adv;

    // handshakes and step enables
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_step     = (r_state == ST_RUN) && (!r_out_valid || i_dot_ready);
    assign w_emit     = w_step && r_rem[0];
    assign w_finish   = w_step && (r_rem == '0) && r_pass;
    assign w_last_dot = (r_rem[GLYPH_DOTS-1:1] == '0) && (r_pass || r_bits == '0);

    // per-item geometry
    assign w_cell = (int'(i_cfg.cell_size) > MAX_CELL) ? 4'(MAX_CELL) : i_cfg.cell_size;
    assign w_n    = (int'(i_cfg.text_length) > MAX_CHARS) ? 7'(MAX_CHARS)
                                                          : i_cfg.text_length;
    assign w_x0   = {{(COORD_W-12){i_cfg.origin_x[11]}}, i_cfg.origin_x};
    assign w_y0   = {{(COORD_W-12){i_cfg.origin_y[11]}}, i_cfg.origin_y};
    assign w_h    = COORD_W'(r_cell) * COORD_W'(GLYPH_H);
    assign w_w    = COORD_W'(r_nm) * COORD_W'(r_cell);
    assign w_adv  = 13'(r_cell) * 13'(ADVANCE_CELLS);

    // dot placement
    assign w_ly = COORD_W'(r_ly);
    always_comb begin
        case (i_cfg.rotation)
            ROT_CW: begin
                w_sx = r_bx1 - w_ly;
                w_sy = w_y0 + r_lx;
            end
            ROT_CCW: begin
                w_sx = w_x0 + w_ly;
                w_sy = r_by2 - r_lx;
            end
            default: begin
                w_sx = w_x0 + r_lx;
                w_sy = w_y0 + w_ly;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cursor <= '0;
            r_pass   <= 1'b1;
            r_rem    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_bits      <= glyph_bits(glyph_index(i_char_code));
                        r_last_text <= i_last_in_text;
                        r_pass      <= !i_cfg.grid_enable;
                        r_cell      <= w_cell;
                        r_side      <= (w_cell > 4'd1) ? w_cell - 4'd1 : 4'd1;
                        r_nm        <= (w_n == '0) ? '0 : 10'(w_n) * 10'(ADVANCE_CELLS) - 10'd1;
                        r_state     <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_bx1   <= w_x0 + w_h - COORD_W'(r_side);
                    r_by2   <= w_y0 + w_w - COORD_W'(r_side);
                    r_rem   <= r_pass ? r_bits : ~r_bits;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_lx    <= COORD_W'(r_cursor);
                    r_ly    <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (w_step) begin
                        if (r_rem == '0) begin
                            if (!r_pass) begin
                                // grid pass done, rescan for lit dots
                                r_pass <= 1'b1;
                                r_rem  <= r_bits;
                                r_col  <= '0;
                                r_row  <= '0;
                                r_lx   <= COORD_W'(r_cursor);
                                r_ly   <= '0;
                            end else begin
                                r_cursor <= r_last_text ? '0 : r_cursor + w_adv;
                                r_state  <= ST_IDLE;
                            end
                        end else begin
                            r_rem <= r_rem >> 1;
                            if (r_col == 3'(GLYPH_W - 1)) begin
                                r_col <= '0;
                                r_row <= r_row + 3'd1;
                                r_lx  <= COORD_W'(r_cursor);
                                r_ly  <= r_ly + 7'(r_cell);
                            end else begin
                                r_col <= r_col + 3'd1;
                                r_lx  <= r_lx + COORD_W'(r_cell);
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_dot_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_x      <= w_sx;
            r_out_y      <= w_sy;
            r_out_colour <= r_pass ? i_cfg.on_colour : i_cfg.off_colour;
            r_out_lit    <= r_pass;
            r_out_last   <= w_last_dot;
        end
    end

    assign o_dot_valid    = r_out_valid;
    assign o_rect_x       = r_out_x;
    assign o_rect_y       = r_out_y;
    assign o_rect_side    = r_side;
    assign o_dot_colour   = r_out_colour;
    assign o_dot_lit      = r_out_lit;
    assign o_last_of_char = r_out_last;

    // checks
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last_dot) |=> (r_rem == '0))
        else $error("dots remain after the final dot of a character");

    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_finish) |=> $stable(r_cursor))
        else $error("cursor moved outside the end of a character");

    a_grid_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !r_pass) |-> i_cfg.grid_enable)
        else $error("unlit pass without grid enabled");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_rem != '0) |-> (r_row < 3'(GLYPH_H) && r_col < 3'(GLYPH_W)))
        else $error("scan position outside the glyph while dots remain");

endmodule

/* hw/rtl/dot_matrix_text_renderer.sv */
// ----------------------------------------------------------------------------
// dot_matrix_text_renderer
// 5x7 dot-matrix character generator producing one square rectangle per dot.
// ----------------------------------------------------------------------------
// One character enters per request on the slave stream; the block emits its
// dots as rectangles, at most one per clock, grid (unlit) dots first when the
// grid is on, then lit dots, each in row-major order. A character goes through
// the accept and setup states of the dot sequencer, which then steps one glyph
// position per cycle up to the last drawn dot of each pass and closes each
// pass with a further step; steps wait while the output rectangle is held
// back. A blank character with the grid off gives no rectangles. The next
// character is taken once the sequencer closes; its last rectangle is out by then.
// Configuration writes take effect at once; the user must make them only
// while no character is in work, as the block does not enforce this.
// ----------------------------------------------------------------------------
module dot_matrix_text_renderer
    import dmtr_pkg::*;
#(
    parameter int MAX_CHARS = 64,
    parameter int MAX_CELL  = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // character stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_in_text
    // rectangle stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [13:0] rect_x, [27:14] rect_y,
                                        // [31:28] rect_side, [47:32] dot_colour
    output logic        m_axis_tuser,   // dot_lit
    output logic        m_axis_tlast    // last_of_char
);

    t_cfg               r_cfg;
    logic [COORD_W-1:0] w_rect_x;
    logic [COORD_W-1:0] w_rect_y;
    logic [3:0]         w_rect_side;
    logic [15:0]        w_dot_colour;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.cell_size   <= 4'd4;
            r_cfg.rotation    <= '0;
            r_cfg.grid_enable <= 1'b0;
            r_cfg.text_length <= '0;
            r_cfg.on_colour   <= 16'hFFFF;
            r_cfg.off_colour  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ORIGIN_X:    r_cfg.origin_x    <= i_cfg_data[11:0];
                REG_ORIGIN_Y:    r_cfg.origin_y    <= i_cfg_data[11:0];
                REG_CELL_SIZE:   r_cfg.cell_size   <= i_cfg_data[3:0];
                REG_ROTATION:    r_cfg.rotation    <= i_cfg_data[1:0];
                REG_GRID_ENABLE: r_cfg.grid_enable <= i_cfg_data[0];
                REG_TEXT_LENGTH: r_cfg.text_length <= i_cfg_data[6:0];
                REG_ON_COLOUR:   r_cfg.on_colour   <= i_cfg_data;
                REG_OFF_COLOUR:  r_cfg.off_colour  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dot sequencer
    dmtr_seq #(
        .MAX_CHARS (MAX_CHARS),
        .MAX_CELL  (MAX_CELL)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_char_code    (s_axis_tdata),
        .i_last_in_text (s_axis_tlast),
        .o_dot_valid    (m_axis_tvalid),
        .i_dot_ready    (m_axis_tready),
        .o_rect_x       (w_rect_x),
        .o_rect_y       (w_rect_y),
        .o_rect_side    (w_rect_side),
        .o_dot_colour   (w_dot_colour),
        .o_dot_lit      (m_axis_tuser),
        .o_last_of_char (m_axis_tlast)
    );

    assign m_axis_tdata = {w_dot_colour, w_rect_side, w_rect_y, w_rect_x};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 5x7 dot-matrix text renderer.
// ----------------------------------------------------------------------------
// Characters are streamed in with random gaps. Each accepted character is
// expanded here into its expected dot rectangles: own glyph table, grid and
// lit passes, rotation, cursor advance. Those rectangles are then compared
// field by field with what comes out on the rectangle stream. The register
// set is changed between texts, only once the block has gone quiet. The run
// covers the extremes: zero and full cell pitch, every rotation code,
// saturated text length, anchor corners, cursor wrap and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import dmtr_pkg::*;

    localparam int IDLE_PCT    = 23;
    localparam int QUIET_WAIT  = 100;   // longest character plus output slot
    localparam int STALL_LEN   = 300;
    localparam int SHOW_ERRORS = 10;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    typedef struct packed {
        logic [13:0] x;
        logic [13:0] y;
        logic [3:0]  side;
        logic [15:0] colour;
        logic        lit;
        logic        last;
    } dot_rect_t;

    // DUT connections
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] char_code
    logic        s_axis_tlast  = 1'b0; // last_in_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [13:0] rect_x, [27:14] rect_y,
                                       // [31:28] rect_side, [47:32] dot_colour
    logic        m_axis_tuser;         // dot_lit
    logic        m_axis_tlast;         // last_of_char

    // predictor copy of the register set and the column cursor
    logic [11:0] set_origin_x = '0;
    logic [11:0] set_origin_y = '0;
    logic [3:0]  set_cell     = 4'd4;
    logic [1:0]  set_rotation = '0;
    logic        set_grid     = 1'b0;
    logic [6:0]  set_len      = '0;
    logic [15:0] set_on       = 16'hFFFF;
    logic [15:0] set_off      = '0;
    logic [12:0] pen_x        = '0;

    text_char_t  char_send_q[$];
    dot_rect_t   rect_expect_q[$];

    logic        char_took      = 1'b0;
    logic        no_idle        = 1'b0;
    logic        stall_armed    = 1'b0;
    logic        stall_done     = 1'b0;
    int          stall_left     = 0;
    int          mismatch_count = 0;
    int          chars_in       = 0;
    int          rects_out      = 0;
    int          grid_dots      = 0;
    int          settings_used  = 1;

    // glyph rows, 7 per glyph, bit 4 is the leftmost column
    logic [4:0] font_rows [0:307] = '{
        'h0E,'h11,'h13,'h15,'h19,'h11,'h0E,  'h04,'h0C,'h04,'h04,'h04,'h04,'h0E,
        'h0E,'h11,'h01,'h02,'h04,'h08,'h1F,  'h1F,'h02,'h04,'h02,'h01,'h11,'h0E,
        'h02,'h06,'h0A,'h12,'h1F,'h02,'h02,  'h1F,'h10,'h1E,'h01,'h01,'h11,'h0E,
        'h06,'h08,'h10,'h1E,'h11,'h11,'h0E,  'h1F,'h01,'h02,'h04,'h08,'h08,'h08,
        'h0E,'h11,'h11,'h0E,'h11,'h11,'h0E,  'h0E,'h11,'h11,'h0F,'h01,'h02,'h0C,
        'h0E,'h11,'h11,'h1F,'h11,'h11,'h11,  'h1E,'h11,'h11,'h1E,'h11,'h11,'h1E,
        'h0E,'h11,'h10,'h10,'h10,'h11,'h0E,  'h1C,'h12,'h11,'h11,'h11,'h12,'h1C,
        'h1F,'h10,'h10,'h1E,'h10,'h10,'h1F,  'h1F,'h10,'h10,'h1E,'h10,'h10,'h10,
        'h0E,'h11,'h10,'h17,'h11,'h11,'h0F,  'h11,'h11,'h11,'h1F,'h11,'h11,'h11,
        'h0E,'h04,'h04,'h04,'h04,'h04,'h0E,  'h07,'h02,'h02,'h02,'h02,'h12,'h0C,
        'h11,'h12,'h14,'h18,'h14,'h12,'h11,  'h10,'h10,'h10,'h10,'h10,'h10,'h1F,
        'h11,'h1B,'h15,'h15,'h11,'h11,'h11,  'h11,'h11,'h19,'h15,'h13,'h11,'h11,
        'h0E,'h11,'h11,'h11,'h11,'h11,'h0E,  'h1E,'h11,'h11,'h1E,'h10,'h10,'h10,
        'h0E,'h11,'h11,'h11,'h15,'h12,'h0D,  'h1E,'h11,'h11,'h1E,'h14,'h12,'h11,
        'h0F,'h10,'h10,'h0E,'h01,'h01,'h1E,  'h1F,'h04,'h04,'h04,'h04,'h04,'h04,
        'h11,'h11,'h11,'h11,'h11,'h11,'h0E,  'h11,'h11,'h11,'h11,'h11,'h0A,'h04,
        'h11,'h11,'h11,'h15,'h15,'h1B,'h11,  'h11,'h11,'h0A,'h04,'h0A,'h11,'h11,
        'h11,'h11,'h0A,'h04,'h04,'h04,'h04,  'h1F,'h01,'h02,'h04,'h08,'h10,'h1F,
        'h00,'h00,'h00,'h00,'h00,'h00,'h00,  'h00,'h04,'h04,'h00,'h04,'h04,'h00,
        'h01,'h02,'h02,'h04,'h08,'h08,'h10,  'h00,'h00,'h00,'h1F,'h00,'h00,'h00,
        'h00,'h00,'h00,'h00,'h00,'h0C,'h0C,  'h02,'h04,'h08,'h10,'h08,'h04,'h02,
        'h08,'h04,'h02,'h01,'h02,'h04,'h08,  'h00,'h04,'h04,'h1F,'h04,'h04,'h00
    };

    dot_matrix_text_renderer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // character code to glyph slot: fold case, unknown codes draw blank
    function automatic int glyph_slot(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= "a" && c <= "z") c = c - 8'd32;
        if (c >= "A" && c <= "Z") return 10 + int'(c - "A");
        if (c >= "0" && c <= "9") return int'(c - "0");
        case (c)
            ":":     return 37;
            "/":     return 38;
            "-":     return 39;
            ".":     return 40;
            "<":     return 41;
            ">":     return 42;
            "+":     return 43;
            default: return GLYPH_SPACE;
        endcase
    endfunction

    // expand one character into its rectangles and move the cursor on
    task automatic render_char_dots(input logic [7:0] code, input logic last);
        int        slot, pitch, side, cols, span_w, span_h, x0, y0;
        int        lx, ly, sx, sy;
        logic      lit;
        logic      held;
        dot_rect_t dot, prev;
        slot   = glyph_slot(code);
        pitch  = int'(set_cell);
        side   = (pitch - 1 < 1) ? 1 : pitch - 1;
        cols   = (set_len > 7'd64) ? 64 : int'(set_len);
        span_w = (cols == 0) ? 0 : (cols * 6 - 1) * pitch;
        span_h = 7 * pitch;
        x0     = int'($signed(set_origin_x));
        y0     = int'($signed(set_origin_y));
        held   = 1'b0;
        prev   = '0;
        for (int pass = (set_grid ? 0 : 1); pass <= 1; pass++) begin
            for (int r = 0; r < 7; r++) begin
                for (int k = 0; k < 5; k++) begin
                    lit = font_rows[slot * 7 + r][4 - k];
                    if (int'(lit) == pass) begin
                        lx = int'(pen_x) + k * pitch;
                        ly = r * pitch;
                        case (set_rotation)
                            ROT_CW: begin
                                sx = x0 + span_h - ly - side;
                                sy = y0 + lx;
                            end
                            ROT_CCW: begin
                                sx = x0 + ly;
                                sy = y0 + span_w - lx - side;
                            end
                            default: begin
                                sx = x0 + lx;
                                sy = y0 + ly;
                            end
                        endcase
                        dot.x      = sx[13:0];
                        dot.y      = sy[13:0];
                        dot.side   = side[3:0];
                        dot.colour = lit ? set_on : set_off;
                        dot.lit    = lit;
                        dot.last   = 1'b0;
                        if (held) rect_expect_q.push_back(prev);
                        prev = dot;
                        held = 1'b1;
                    end
                end
            end
        end
        // final rectangle of the character carries the end marker
        if (held) begin
            prev.last = 1'b1;
            rect_expect_q.push_back(prev);
        end
        if (last) pen_x = '0;
        else      pen_x = pen_x + 13'(6 * pitch);
    endtask

    // request monitor and result checker
    always @(posedge i_clk) begin
        dot_rect_t got, want;
        char_took <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            render_char_dots(s_axis_tdata, s_axis_tlast);
            chars_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x      = m_axis_tdata[13:0];
            got.y      = m_axis_tdata[27:14];
            got.side   = m_axis_tdata[31:28];
            got.colour = m_axis_tdata[47:32];
            got.lit    = m_axis_tuser;
            got.last   = m_axis_tlast;
            rects_out++;
            if (!got.lit) grid_dots++;
            if (rect_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_ERRORS)
                    $display("%0t: unexpected rect x=%0d y=%0d side=%0d col=%h lit=%b last=%b",
                             $realtime, $signed(got.x), $signed(got.y), got.side,
                             got.colour, got.lit, got.last);
            end else begin
                want = rect_expect_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.side !== want.side ||
                    got.colour !== want.colour || got.lit !== want.lit ||
                    got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_ERRORS) begin
                        $display("%0t: rect mismatch", $realtime);
                        $display("  expected x=%0d y=%0d side=%0d col=%h lit=%b last=%b",
                                 $signed(want.x), $signed(want.y), want.side,
                                 want.colour, want.lit, want.last);
                        $display("  actual   x=%0d y=%0d side=%0d col=%h lit=%b last=%b",
                                 $signed(got.x), $signed(got.y), got.side,
                                 got.colour, got.lit, got.last);
                    end
                end
            end
        end
    end

    // character driver: next request once the current one is taken
    always @(negedge i_clk) begin
        text_char_t item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || char_took) begin
            if (char_send_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                item = char_send_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= item.code;
                s_axis_tlast  <= item.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // rectangle sink: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (stall_armed && !stall_done) begin
            m_axis_tready <= 1'b0;
            stall_left    <= STALL_LEN;
            stall_done    <= 1'b1;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_ORIGIN_X:    set_origin_x = value[11:0];
            REG_ORIGIN_Y:    set_origin_y = value[11:0];
            REG_CELL_SIZE:   set_cell     = value[3:0];
            REG_ROTATION:    set_rotation = value[1:0];
            REG_GRID_ENABLE: set_grid     = value[0];
            REG_TEXT_LENGTH: set_len      = value[6:0];
            REG_ON_COLOUR:   set_on       = value;
            REG_OFF_COLOUR:  set_off      = value;
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_settings();
        write_reg(REG_ORIGIN_X,    16'($urandom_range(4095)));
        write_reg(REG_ORIGIN_Y,    16'($urandom_range(4095)));
        write_reg(REG_CELL_SIZE,   16'($urandom_range(15)));
        write_reg(REG_ROTATION,    16'($urandom_range(3)));
        write_reg(REG_GRID_ENABLE, 16'($urandom_range(1)));
        write_reg(REG_TEXT_LENGTH, 16'($urandom_range(127)));
        write_reg(REG_ON_COLOUR,   16'($urandom));
        write_reg(REG_OFF_COLOUR,  16'($urandom));
        close_writes();
    endtask

    task automatic send_char(input logic [7:0] code, input logic last);
        text_char_t item;
        item.code = code;
        item.last = last;
        char_send_q.push_back(item);
    endtask

    // mostly drawable characters, some lowercase, blanks and raw bytes
    function automatic logic [7:0] pick_char();
        string drawable;
        int    pick;
        drawable = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ:/-.<>+";
        pick     = $urandom_range(99);
        if (pick < 50) return drawable[$urandom_range(drawable.len() - 1)];
        if (pick < 70) return 8'($urandom_range(8'h7A, 8'h61));
        if (pick < 82) return " ";
        return 8'($urandom_range(255));
    endfunction

    // one text: the final character ends it, a few stray end marks mid-way
    task automatic send_text(input int count, input bit closed);
        for (int i = 0; i < count; i++)
            send_char(pick_char(), (closed && i == count - 1) || ($urandom_range(99) < 4));
    endtask

    // wait until every request is taken and every rectangle is back
    task automatic wait_quiet();
        while (char_send_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (rect_expect_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_WAIT) @(posedge i_clk);
    endtask

    // ~300 chars, up to 35 rectangles each, plus the stalls: far under this
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        string directed;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed: every symbol, case fold, blank, raw byte extremes
        directed = "Az09:/-.<>+ m";
        for (int i = 0; i < directed.len(); i++) send_char(directed[i], 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char("Q", 1'b1);
        wait_quiet();

        // grid on, clockwise, finest pitch
        write_reg(REG_GRID_ENABLE, 16'd1);
        write_reg(REG_ROTATION,    16'(ROT_CW));
        write_reg(REG_CELL_SIZE,   16'd1);
        write_reg(REG_TEXT_LENGTH, 16'd10);
        write_reg(REG_ON_COLOUR,   16'h0000);
        write_reg(REG_OFF_COLOUR,  16'hFFFF);
        close_writes();
        send_text(20, 1'b1);
        wait_quiet();

        // counter-clockwise, widest pitch, full text, most negative anchor
        write_reg(REG_ORIGIN_X,    16'h0800);
        write_reg(REG_ORIGIN_Y,    16'h0800);
        write_reg(REG_ROTATION,    16'(ROT_CCW));
        write_reg(REG_CELL_SIZE,   16'd15);
        write_reg(REG_TEXT_LENGTH, 16'd64);
        close_writes();
        send_text(30, 1'b1);
        wait_quiet();

        // spare rotation code, zero pitch, length past the maximum
        write_reg(REG_ROTATION,    16'd3);
        write_reg(REG_CELL_SIZE,   16'd0);
        write_reg(REG_GRID_ENABLE, 16'd0);
        write_reg(REG_TEXT_LENGTH, 16'd127);
        close_writes();
        send_text(20, 1'b1);
        wait_quiet();

        // largest anchor and pitch, one long text so the cursor wraps
        write_reg(REG_ORIGIN_X,    16'h07FF);
        write_reg(REG_ORIGIN_Y,    16'h07FF);
        write_reg(REG_CELL_SIZE,   16'd15);
        write_reg(REG_ROTATION,    16'd0);
        write_reg(REG_TEXT_LENGTH, 16'd0);
        close_writes();
        for (int i = 0; i < 100; i++) send_char(pick_char(), i == 99);
        wait_quiet();

        // long output hold-off while characters keep coming
        random_settings();
        write_reg(REG_GRID_ENABLE, 16'd1);
        write_reg(REG_CELL_SIZE,   16'd7);
        close_writes();
        stall_armed = 1'b1;
        send_text(40, 1'b1);
        wait_quiet();

        // back-to-back stretch with no gaps on either side
        random_settings();
        no_idle = 1'b1;
        send_text(40, 1'b1);
        wait_quiet();
        no_idle = 1'b0;

        for (int p = 0; p < 3; p++) begin
            random_settings();
            send_text(10, 1'b1);
            wait_quiet();
        end

        if (rect_expect_q.size() != 0) mismatch_count++;
        $display("Checked %0d characters -> %0d dot rectangles (%0d grid dots)",
                 chars_in, rects_out, grid_dots);
        $display("over %0d register settings, all rotation codes, pitches 0 to 15.",
                 settings_used);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
